@@ sv/u8u16sp_pkg.sv @@
// shared types and constants for the utf-8 to utf-16be payload encoder
package u8u16sp_pkg;

  localparam int unsigned BufferBytesDef = 256;

  localparam logic [7:0] FrameHeader  = 8'hFD;
  localparam logic [7:0] CmdSpeak     = 8'h01;
  localparam logic [3:0] ParamLowNib  = 4'h3;
  localparam logic [15:0] HdrExtra    = 16'd3;
  localparam logic [20:0] SurrFirst   = 21'h00D800;
  localparam logic [20:0] SurrLast    = 21'h00DFFF;
  localparam logic [20:0] SuppBase    = 21'h010000;
  localparam logic [20:0] CodeMax     = 21'h10FFFF;
  localparam logic [20:0] TwoByteMin  = 21'h000080;
  localparam logic [20:0] ThreeByteMin = 21'h000800;
  localparam logic [5:0] HiSurrTag    = 6'b110110;
  localparam logic [5:0] LoSurrTag    = 6'b110111;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatInvalid  = 2'd1,
    StatCapacity = 2'd2
  } status_e;

  // one accepted item's results, handed from decoder to output stage
  typedef struct packed {
    logic            valid;    // item caused at least one result
    logic            summary;  // end summary instead of payload bytes
    logic            four;     // surrogate pair: four payload bytes
    logic [3:0][7:0] bytes;    // payload bytes, index 0 goes out first
    status_e         status;
    logic [8:0]      base_len; // count before first byte, or final length
    logic [7:0]      ck;
  } res_t;

endpackage

@@ sv/u8u16sp_decode.sv @@
// utf-8 decoder, validator, byte counter and checksum state
module u8u16sp_decode import u8u16sp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] text_byte_i,
  output res_t       res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1);

  logic [3:0]      vm_q;
  logic [1:0]      pend_q, pend_d;
  logic [1:0]      seq_q, seq_d;
  logic [20:0]     part_q, part_d;
  status_e         err_q, err_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;

  logic [16:0]     cnt_ext;
  logic [15:0]     pkt_len;
  logic [7:0]      param_byte;

  assign cnt_ext    = 17'(cnt_q);
  assign pkt_len    = cnt_ext[15:0] + HdrExtra;
  assign param_byte = {vm_q, ParamLowNib};

  always_comb begin
    logic        do_emit;
    logic        bad;
    logic        four;
    logic [20:0] cp;
    logic [20:0] nxt_part;
    logic [19:0] s;
    logic [15:0] hi, lo;
    logic [3:0][7:0] bts;
    logic [CntW:0] sum;
    pend_d   = pend_q;
    seq_d    = seq_q;
    part_d   = part_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    res_o    = '0;
    do_emit  = 1'b0;
    bad      = 1'b0;
    cp       = '0;
    nxt_part = {part_q[14:0], text_byte_i[5:0]};

    if (accept_i) begin
      if (action_i) begin
        res_o.valid   = 1'b1;
        res_o.summary = 1'b1;
        if (err_q != StatOk) begin
          res_o.status = err_q;
        end else if (pend_q != 2'd0) begin
          res_o.status = StatInvalid;
        end else begin
          res_o.status   = StatOk;
          res_o.base_len = cnt_ext[8:0];
          res_o.ck = FrameHeader ^ pkt_len[15:8] ^ pkt_len[7:0] ^ CmdSpeak
                     ^ param_byte ^ xor_q;
        end
        pend_d = '0;
        seq_d  = '0;
        part_d = '0;
        err_d  = StatOk;
        cnt_d  = '0;
        xor_d  = '0;
      end else if (err_q == StatOk) begin
        if (pend_q == 2'd0) begin
          if (!text_byte_i[7]) begin
            cp      = 21'(text_byte_i);
            do_emit = 1'b1;
          end else if (text_byte_i[7:5] == 3'b110) begin
            part_d = 21'(text_byte_i[4:0]);
            seq_d  = 2'd1;
            pend_d = 2'd1;
          end else if (text_byte_i[7:4] == 4'b1110) begin
            part_d = 21'(text_byte_i[3:0]);
            seq_d  = 2'd2;
            pend_d = 2'd2;
          end else if (text_byte_i[7:3] == 5'b11110) begin
            part_d = 21'(text_byte_i[2:0]);
            seq_d  = 2'd3;
            pend_d = 2'd3;
          end else begin
            err_d = StatInvalid;
          end
        end else if (text_byte_i[7:6] != 2'b10) begin
          err_d = StatInvalid;
        end else if (pend_q != 2'd1) begin
          part_d = nxt_part;
          pend_d = pend_q - 2'd1;
        end else begin
          // sequence complete: reject overlong, surrogate and out of range
          case (seq_q)
            2'd1:    bad = nxt_part < TwoByteMin;
            2'd2:    bad = nxt_part < ThreeByteMin ||
                           (nxt_part >= SurrFirst && nxt_part <= SurrLast);
            default: bad = nxt_part < SuppBase || nxt_part > CodeMax;
          endcase
          pend_d = '0;
          seq_d  = '0;
          part_d = '0;
          if (bad) begin
            err_d = StatInvalid;
          end else begin
            cp      = nxt_part;
            do_emit = 1'b1;
          end
        end
      end
    end

    four = cp >= SuppBase;
    s    = 20'(cp - SuppBase);
    hi   = {HiSurrTag, s[19:10]};
    lo   = {LoSurrTag, s[9:0]};
    if (four) begin
      bts = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
    end else begin
      bts = {16'h0000, cp[7:0], cp[15:8]};
    end
    sum = {1'b0, cnt_q} + (four ? (CntW+1)'(4) : (CntW+1)'(2));

    if (do_emit) begin
      if (sum > (CntW+1)'(BUFFER_BYTES)) begin
        err_d = StatCapacity;
      end else begin
        res_o.valid    = 1'b1;
        res_o.four     = four;
        res_o.bytes    = bts;
        res_o.status   = StatOk;
        res_o.base_len = cnt_ext[8:0];
        cnt_d          = sum[CntW-1:0];
        xor_d          = xor_q ^ bts[0] ^ bts[1] ^ bts[2] ^ bts[3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q   <= '0;
      pend_q <= '0;
      seq_q  <= '0;
      part_q <= '0;
      err_q  <= StatOk;
      cnt_q  <= '0;
      xor_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        vm_q <= cfg_data_i;
      end
      pend_q <= pend_d;
      seq_q  <= seq_d;
      part_q <= part_d;
      err_q  <= err_d;
      cnt_q  <= cnt_d;
      xor_q  <= xor_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BUFFER_BYTES))
    else $error("payload count beyond buffer capacity");

  a_pend_le_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= seq_q)
    else $error("more continuations pending than announced");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && action_i |=> cnt_q == '0 && err_q == StatOk && pend_q == 2'd0)
    else $error("string state not cleared after end");

endmodule

@@ sv/u8u16sp_serial.sv @@
// result register and serializer: one result transfer per cycle while the receiver is ready
module u8u16sp_serial import u8u16sp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       in_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic       m_kind_o,
  output logic       m_last_o,
  output logic [7:0] m_data_o,
  output status_e    m_status_o,
  output logic [8:0] m_len_o,
  output logic [7:0] m_ck_o
);

  res_t       res_q;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       last;

  assign last       = res_q.summary || idx_q == (res_q.four ? 2'd3 : 2'd1);
  assign in_ready_o = !valid_q || (m_ready_i && last);

  assign m_valid_o  = valid_q;
  assign m_kind_o   = res_q.summary;
  assign m_last_o   = last;
  assign m_data_o   = res_q.summary ? 8'h00 : res_q.bytes[idx_q];
  assign m_status_o = res_q.summary ? res_q.status : StatOk;
  assign m_len_o    = res_q.summary ? res_q.base_len
                                    : res_q.base_len + 9'(idx_q) + 9'd1;
  assign m_ck_o     = res_q.summary ? res_q.ck : 8'h00;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = res_i.valid;
      idx_d   = '0;
    end else if (valid_q && m_ready_i) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_idx_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.four && !res_q.summary |-> idx_q <= 2'd1)
    else $error("byte index past a two byte unit");

  a_idx_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.summary |-> idx_q == 2'd0)
    else $error("summary not sent as a single transfer");

  a_keep_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && m_ready_i && !last |=> valid_q && idx_q == $past(idx_q) + 2'd1)
    else $error("unit dropped before its last byte");

endmodule

@@ sv/utf8_to_utf16be_speech_payload.sv @@
// top level of the utf-8 to utf-16be speech payload encoder
//
// input stream: one transfer per item. s_axis_tuser = 1 marks end of string,
// 0 marks a text byte carried in s_axis_tdata.
// output stream: payload bytes (m_axis_tuser = 0), two per bmp code point and
// four per surrogate pair, then one end summary (m_axis_tuser = 1) with status,
// payload length and the xor checksum of the whole speech frame.
// m_axis_tlast marks the last transfer caused by one input item.
// cfg_we_i/cfg_data_i write the background music selector; write while idle.
//
// results are registered and appear in the cycle after the input transfer.
// an item is taken when the output register is empty or while the previous
// unit's last result leaves, so a byte that finishes a code point holds off the
// next item until all its payload bytes are sent by the serializer register.
// a stalled receiver holds the output and back-pressures the input through
// s_axis_tready; nothing is lost or repeated.
// reset clears all string state, the music selector and the output valid flag and byte index.
module utf8_to_utf16be_speech_payload import u8u16sp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,     // voice_music
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                      // [18:10] text_length, [26:19] frame_checksum
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  logic       accept;
  res_t       res;
  status_e    status;
  logic [7:0] data_byte;
  logic [8:0] len_out;
  logic [7:0] ck;

  // transfer on the input side
  assign accept = s_axis_tvalid && s_axis_tready;

  u8u16sp_decode #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .action_i    (s_axis_tuser),
    .text_byte_i (s_axis_tdata),
    .res_o       (res)
  );

  u8u16sp_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .in_ready_o (s_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_kind_o   (m_axis_tuser),
    .m_last_o   (m_axis_tlast),
    .m_data_o   (data_byte),
    .m_status_o (status),
    .m_len_o    (len_out),
    .m_ck_o     (ck)
  );

  // pack output fields, lowest first, zero fill to whole bytes
  assign m_axis_tdata = {5'b00000, ck, len_out, status, data_byte};

endmodule

@@ sim/tb_utf8_to_utf16be_speech_payload.sv @@
// self-checking testbench for the utf-8 to utf-16be speech payload encoder
`timescale 1ns / 1ps

module tb_utf8_to_utf16be_speech_payload;
  import u8u16sp_pkg::*;

  localparam logic ActText     = 1'b0;
  localparam logic ActEnd      = 1'b1;
  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;
  localparam int unsigned CycleLimit = 400000;

  // one input transfer: action on tuser, text byte on tdata
  typedef struct packed {
    logic       act;
    logic [7:0] b;
  } text_item_t;

  // one output transfer as the encoder should produce it
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    status_e    status;
    logic [8:0] len;
    logic [7:0] ck;
  } u16_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_data_i = 4'h0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = ActText;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  utf8_to_utf16be_speech_payload #(
    .BUFFER_BYTES(BufferBytesDef)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // stimulus and expectations
  text_item_t  text_items[$];
  u16_rec_t    awaited_u16[$];
  int unsigned queued_total = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        in_taken = 1'b0;
  u16_rec_t    want_rec;
  text_item_t  next_item;

  // predictor state, mirrors the encoder's string state
  logic [3:0]  music_sel = 4'h0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  lead_len = '0;
  logic [20:0] cp_acc = '0;
  status_e     str_status = StatOk;
  logic [8:0]  out_count = '0;
  logic [7:0]  out_xor = '0;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40) begin
      $display("mismatch %s at cycle %0d: got %0h expected %0h", what, cycles, got, want);
    end
    mismatches++;
  endtask

  // payload bytes of one code point, unless they would overflow the buffer
  task automatic emit_code_point(input logic [20:0] cp);
    logic [7:0]  ub [4];
    logic [19:0] off;
    int          n;
    u16_rec_t    r;
    if (cp <= 21'h00FFFF) begin
      ub[0] = cp[15:8];
      ub[1] = cp[7:0];
      n = 2;
    end else begin
      off = 20'(cp - SuppBase);
      {ub[0], ub[1]} = {HiSurrTag, off[19:10]};
      {ub[2], ub[3]} = {LoSurrTag, off[9:0]};
      n = 4;
    end
    if (int'(out_count) + n > BufferBytesDef) begin
      str_status = StatCapacity;
    end else begin
      for (int k = 0; k < n; k++) begin
        out_count++;
        out_xor ^= ub[k];
        r = '{kind: KindPayload, data: ub[k], last: (k == n - 1), status: StatOk,
              len: out_count, ck: 8'h00};
        awaited_u16.push_back(r);
      end
    end
  endtask

  // advance the predicted decoder by one accepted transfer
  task automatic transcode_item(input logic act, input logic [7:0] b);
    logic [15:0] fl;
    logic [20:0] cp;
    logic        bad;
    u16_rec_t    r;
    if (act == ActEnd) begin
      r = '{kind: KindSummary, data: 8'h00, last: 1'b1, status: str_status,
            len: 9'd0, ck: 8'h00};
      // an open sequence at end counts as invalid unless an error came first
      if (str_status == StatOk && cont_left != 0) r.status = StatInvalid;
      if (r.status == StatOk) begin
        fl = 16'(out_count) + HdrExtra;
        r.len = out_count;
        r.ck = FrameHeader ^ fl[15:8] ^ fl[7:0] ^ CmdSpeak ^ {music_sel, ParamLowNib} ^
               out_xor;
      end
      awaited_u16.push_back(r);
      cont_left = '0;
      lead_len = '0;
      cp_acc = '0;
      str_status = StatOk;
      out_count = '0;
      out_xor = '0;
    end else if (str_status != StatOk) begin
      // text after an error is dropped until end
    end else if (cont_left == 0) begin
      casez (b)
        8'b0???????: emit_code_point({13'd0, b});
        8'b110?????: begin
          cp_acc = {16'd0, b[4:0]};
          lead_len = 2'd1;
          cont_left = 2'd1;
        end
        8'b1110????: begin
          cp_acc = {17'd0, b[3:0]};
          lead_len = 2'd2;
          cont_left = 2'd2;
        end
        8'b11110???: begin
          cp_acc = {18'd0, b[2:0]};
          lead_len = 2'd3;
          cont_left = 2'd3;
        end
        default: str_status = StatInvalid;
      endcase
    end else if (b[7:6] != 2'b10) begin
      str_status = StatInvalid;
    end else begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      cont_left--;
      if (cont_left == 0) begin
        cp = cp_acc;
        case (lead_len)
          2'd1:    bad = cp < TwoByteMin;
          2'd2:    bad = cp < ThreeByteMin || (cp >= SurrFirst && cp <= SurrLast);
          default: bad = cp < SuppBase || cp > CodeMax;
        endcase
        cp_acc = '0;
        lead_len = '0;
        if (bad) str_status = StatInvalid;
        else emit_code_point(cp);
      end
    end
  endtask

  // input side: one item per transfer, random idle bursts between items
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        send_gap = $urandom_range(16, 0);
        s_axis_tvalid <= 1'b0;
      end else if (text_items.size() != 0) begin
        next_item = text_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_item.act;
        s_axis_tdata <= next_item.b;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stall bursts on tready
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(16, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // predict on each input transfer, then check each output transfer
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (rst_ni && s_axis_tvalid && s_axis_tready) begin
        transcode_item(s_axis_tuser, s_axis_tdata);
      end
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (awaited_u16.size() == 0) begin
          note_mismatch("unexpected transfer", m_axis_tdata, 32'd0);
        end else begin
          want_rec = awaited_u16.pop_front();
          if (m_axis_tuser !== want_rec.kind)
            note_mismatch("kind", m_axis_tuser, want_rec.kind);
          if (m_axis_tdata[7:0] !== want_rec.data)
            note_mismatch("data_byte", m_axis_tdata[7:0], want_rec.data);
          if (m_axis_tlast !== want_rec.last)
            note_mismatch("last", m_axis_tlast, want_rec.last);
          if (m_axis_tdata[9:8] !== want_rec.status)
            note_mismatch("status", m_axis_tdata[9:8], want_rec.status);
          if (m_axis_tdata[18:10] !== want_rec.len)
            note_mismatch("text_length", m_axis_tdata[18:10], want_rec.len);
          if (m_axis_tdata[26:19] !== want_rec.ck)
            note_mismatch("frame_checksum", m_axis_tdata[26:19], want_rec.ck);
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    text_items.push_back('{act: ActText, b: b});
    queued_total++;
  endtask

  // end item carries a random don't-care byte so every tdata bit toggles
  task automatic add_end();
    text_items.push_back('{act: ActEnd, b: 8'($urandom)});
    queued_total++;
  endtask

  // n bytes from w, most significant first
  task automatic add_seq(input int n, input logic [31:0] w);
    for (int k = n - 1; k >= 0; k--) add_byte(w[8*k +: 8]);
  endtask

  task automatic add_cp(input logic [20:0] cp);
    if (cp < 21'h80)
      add_seq(1, {11'd0, cp});
    else if (cp < 21'h800)
      add_seq(2, {16'h0, 3'b110, cp[10:6], 2'b10, cp[5:0]});
    else if (cp < 21'h10000)
      add_seq(3, {8'h0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]});
    else
      add_seq(4, {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10,
                  cp[5:0]});
  endtask

  task automatic fill_ascii(input int n);
    for (int k = 0; k < n; k++) add_byte(8'($urandom_range(127)));
  endtask

  function automatic logic [20:0] pick_cp();
    logic [20:0] v;
    case ($urandom_range(3))
      0: v = 21'($urandom_range(8'h7F));
      1: v = 21'($urandom_range(12'h7FF, 12'h080));
      2: begin
        v = 21'($urandom_range(16'hFFFF, 16'h0800));
        // fold surrogates down into the cjk range
        if (v >= SurrFirst && v <= SurrLast) v = v ^ 21'h004000;
      end
      default: v = 21'($urandom_range(21'h10FFFF, 21'h010000));
    endcase
    return v;
  endfunction

  // one malformed fragment of some kind
  task automatic add_noise();
    logic [7:0] lead;
    case ($urandom_range(5))
      0: add_byte(8'($urandom));
      1: add_seq(2, {16'h0, 4'hE, 4'($urandom), 2'b10, 6'($urandom)});
      2: add_seq(2, {16'h0, 7'b1100000, 1'($urandom), 2'b10, 6'($urandom)});
      3: add_seq(3, {8'h0, 8'hED, 3'b101, 5'($urandom), 2'b10, 6'($urandom)});
      4: begin
        lead = 8'($urandom_range(8'hF7, 8'hF4));
        add_byte(lead);
        if (lead == 8'hF4) add_byte(8'($urandom_range(8'hBF, 8'h90)));
        else add_byte({2'b10, 6'($urandom)});
        add_seq(2, {16'h0, 2'b10, 6'($urandom), 2'b10, 6'($urandom)});
      end
      default: begin
        if ($urandom_range(1) == 0)
          add_seq(3, {8'h0, 8'hE0, 3'b100, 5'($urandom), 2'b10, 6'($urandom)});
        else
          add_seq(4, {8'hF0, 4'b1000, 4'($urandom), 2'b10, 6'($urandom), 2'b10,
                      6'($urandom)});
      end
    endcase
  endtask

  // mostly well-formed strings, some with a broken fragment somewhere
  task automatic add_random_strings(input int unsigned n_items);
    int unsigned start;
    int          ncp;
    start = queued_total;
    while (queued_total - start < n_items) begin
      ncp = $urandom_range(5, 1);
      for (int k = 0; k < ncp; k++) begin
        if ($urandom_range(99) < 8) add_noise();
        else add_cp(pick_cp());
      end
      add_end();
    end
  endtask

  // wait for all queued items to go in and all predicted transfers to come out
  task automatic wait_drained();
    while (text_items.size() != 0 || s_axis_tvalid || awaited_u16.size() != 0)
      @(posedge clk_i);
    // a trailing byte with no result may still sit in the encoder
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_music(input logic [3:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    music_sel = v;
  endtask

  initial begin
    idle_pct = 20;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed strings under the reset music selector
    add_end();                                    // empty string
    add_seq(1, 8'h00);                            // nul is a real code point
    add_seq(1, 8'h7F);
    add_seq(2, 16'hC280);
    add_seq(2, 16'hDFBF);
    add_seq(3, 24'hE0A080);
    add_seq(3, 24'hEFBFBF);
    add_seq(4, 32'hF0908080);                     // first supplementary
    add_seq(4, 32'hF48FBFBF);                     // highest code point
    add_end();
    add_seq(2, 16'hC080);                         // overlong two-byte
    add_end();
    add_seq(3, 24'hE09FBF);                       // overlong three-byte
    add_end();
    add_seq(3, 24'hEDA080);                       // surrogate
    add_end();
    add_seq(4, 32'hF08FBFBF);                     // overlong four-byte
    add_end();
    add_seq(4, 32'hF4908080);                     // above 10ffff
    add_end();
    add_seq(2, 16'h4180);                         // stray continuation
    add_end();
    add_seq(2, 16'hF841);                         // bad lead, rest ignored
    add_end();
    add_seq(2, 16'hC241);                         // missing continuation
    add_end();
    add_seq(2, 16'hE282);                         // cut off by end
    add_end();

    // buffer capacity at the top selector value
    set_music(4'hF);
    fill_ascii(126);
    add_seq(4, 32'hF09F9880);                     // pair fills the buffer exactly
    add_seq(1, 8'h21);                            // one code point too many
    add_end();

    set_music(4'h0);
    idle_pct = 35;
    add_random_strings(8);

    set_music(4'($urandom));
    idle_pct = 50;
    add_random_strings(8);

    // closing stretch at full rate
    idle_pct = 0;
    set_music(4'($urandom));
    add_random_strings(10);

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
